@@ sv/psis_pkg.sv @@
// ----------------------------------------------------------------------------
// psis_pkg
// Shared types, codes and constants of the PRBS identification sequencer.
// ----------------------------------------------------------------------------
package psis_pkg;

  // field widths fixed by the interface
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned RIDX_W   = 9;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // internal widths
  localparam int unsigned TIMER_W  = 17;
  localparam int unsigned DECIM_W  = 8;
  localparam int unsigned SIDX_W   = 10;
  localparam int unsigned LFSR_W   = 9;
  localparam int unsigned GYRO5_W  = 19;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned DELAY_W  = 16;

  // constants of the sequencer
  localparam logic [TIMER_W-1:0] ARM_HOLDOFF = 17'd100;
  localparam logic [SIDX_W-1:0]  SIDX_MAX    = 10'd1023;
  localparam int unsigned        GYRO_GAIN   = 5;

  localparam logic [LFSR_W-1:0] TAPS_ORDER5 = 9'b000010100;
  localparam logic [LFSR_W-1:0] TAPS_ORDER7 = 9'b001100000;
  localparam logic [LFSR_W-1:0] TAPS_ORDER8 = 9'b011000110;
  localparam logic [LFSR_W-1:0] TAPS_ORDER9 = 9'b100010000;

  localparam logic signed [ERR_W:0] ERR_SUM_MAX = 18'sd65535;
  localparam logic signed [ERR_W:0] ERR_SUM_MIN = -18'sd65536;
  localparam logic [ERR_W-1:0]      ERR_SAT_HI  = 17'h0FFFF;
  localparam logic [ERR_W-1:0]      ERR_SAT_LO  = 17'h10000;

  // register reset values
  localparam logic                 RST_IDENT_ENABLE = 1'b0;
  localparam logic [AXIS_W-1:0]    RST_SELECTED_AXIS = 2'd0;
  localparam logic [ORDER_W-1:0]   RST_PRBS_ORDER   = 4'd8;
  localparam logic [DECIM_W-1:0]   RST_DECIMATION   = 8'd8;
  localparam logic [LEVEL_W-1:0]   RST_STIM_LEVEL   = 9'd15;
  localparam logic [DELAY_W-1:0]   RST_START_DELAY  = 16'd62;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_READ = 2'd1,
    CMD_INIT = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDENT_ENABLE  = 3'd0,
    REG_SELECTED_AXIS = 3'd1,
    REG_PRBS_ORDER    = 3'd2,
    REG_DECIMATION    = 3'd3,
    REG_STIM_LEVEL    = 3'd4,
    REG_START_DELAY   = 3'd5
  } cfg_reg_e;

  // identification phases
  typedef enum logic [PHASE_W-1:0] {
    PH_RESET    = 3'd0,
    PH_IDLE     = 3'd1,
    PH_WAIT     = 3'd2,
    PH_PRE      = 3'd3,
    PH_SAMPLES  = 3'd4,
    PH_FINISHED = 3'd5
  } phase_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_INIT = 2'd1,
    ST_EXEC = 2'd2
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic init_start;
    logic init_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_is_init;
    logic init_last;
  } dp_status_t;

  // feedback taps for the selected order
  function automatic logic [LFSR_W-1:0] taps_for(input logic [ORDER_W-1:0] order);
    logic [LFSR_W-1:0] taps;
    unique case (order)
      4'd7:    taps = TAPS_ORDER7;
      4'd8:    taps = TAPS_ORDER8;
      4'd9:    taps = TAPS_ORDER9;
      default: taps = TAPS_ORDER5;
    endcase
    return taps;
  endfunction

endpackage

@@ sv/psis_ram.sv @@
// ----------------------------------------------------------------------------
// psis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/psis_ctrl.sv @@
// ----------------------------------------------------------------------------
// psis_ctrl
// Sequencer control: input acceptance, store init walk, result hand-off.
// ----------------------------------------------------------------------------
module psis_ctrl
  import psis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  ctrl_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    ctrl_o      = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          if (status_i.in_is_init) begin
            ctrl_o.init_start = 1'b1;
            state_d = ST_INIT;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_INIT: begin
        ctrl_o.init_step = 1'b1;
        if (status_i.init_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/psis_datapath.sv @@
// ----------------------------------------------------------------------------
// psis_datapath
// Configuration, phase state, stimulus and capture stores, result register.
// ----------------------------------------------------------------------------
module psis_datapath
  import psis_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES     = 511,
  parameter int unsigned PRESAMPLE_COUNT = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input beat payload
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [RATE_W-1:0] rate_target_i,
  input  logic signed [RATE_W-1:0] gyro_rate_i,
  input  logic [AXIS_W-1:0]        axis_index_i,
  input  logic                     armed_i,
  input  logic                     mode_switch_i,
  input  logic [RIDX_W-1:0]        read_index_i,
  // control
  input  ctrl_cmd_t                ctrl_i,
  output dp_status_t               status_o,
  // result payload
  output logic signed [ERR_W-1:0]  error_rate_o,
  output logic signed [DATA_W-1:0] capture_data_o,
  output logic                     capture_active_o,
  output logic [PHASE_W-1:0]       phase_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned LW = $clog2(MAX_SAMPLES + 1);

  // configuration registers
  logic                ident_en_q;
  logic [AXIS_W-1:0]   sel_axis_q;
  logic [ORDER_W-1:0]  order_q;
  logic [DECIM_W-1:0]  decim_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [DELAY_W-1:0]  delay_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [TIMER_W-1:0]  timer_q, timer_d, timer_mid;
  logic [DECIM_W-1:0]  dc_q, dc_d, dc_inc;
  logic [SIDX_W-1:0]   sidx_q, sidx_d;
  logic [DATA_W-1:0]   acc_q, acc_d, acc_sum;
  logic [LW-1:0]       seq_len_q;

  // init walk
  logic [LFSR_W-1:0]   lfsr_q, lfsr_d, taps_q;
  logic [LW-1:0]       period_q, period_inc;
  logic [DATA_W-1:0]   lvl2, init_word;

  // latched input beat
  cmd_e                       cmd_q;
  logic signed [ERR_W-1:0]    err_base_q;
  logic signed [GYRO5_W-1:0]  gyro5_q;
  logic [AXIS_W-1:0]          axis_q;
  logic                       armed_q;
  logic                       mode_q;
  logic [RIDX_W-1:0]          ridx_q;

  // store ports
  logic                stim_re, stim_rd;
  logic [AW-1:0]       stim_raddr;
  logic                cap_we, cap_re;
  logic [AW-1:0]       cap_waddr;
  logic [DATA_W-1:0]   cap_wdata, cap_rd;

  // tick evaluation
  logic                hit;
  logic                pre_valid, samp_valid;
  logic [LW-1:0]       pre_addr_full;
  logic                inj_en, bit_ok, bit_used;
  logic                cap_we_tick;
  logic signed [LEVEL_W:0]  inj;
  logic signed [ERR_W:0]    err_sum;
  logic [ERR_W-1:0]         err_sat;
  logic [DATA_W-1:0]        tick_word;
  logic [DATA_W-1:0]        read_word;

  // output payload registers
  logic [ERR_W-1:0]    err_out_q;
  logic [DATA_W-1:0]   data_out_q;
  logic                active_out_q;
  phase_e              phase_out_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_en_q <= RST_IDENT_ENABLE;
      sel_axis_q <= RST_SELECTED_AXIS;
      order_q    <= RST_PRBS_ORDER;
      decim_q    <= RST_DECIMATION;
      level_q    <= RST_STIM_LEVEL;
      delay_q    <= RST_START_DELAY;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IDENT_ENABLE:  ident_en_q <= cfg_data_i[0];
        REG_SELECTED_AXIS: sel_axis_q <= cfg_data_i[AXIS_W-1:0];
        REG_PRBS_ORDER:    order_q    <= cfg_data_i[ORDER_W-1:0];
        REG_DECIMATION:    decim_q    <= cfg_data_i[DECIM_W-1:0];
        REG_STIM_LEVEL:    level_q    <= cfg_data_i[LEVEL_W-1:0];
        REG_START_DELAY:   delay_q    <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat capture, with target minus gyro and scaled gyro precomputed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q      <= cmd_e'(cmd_i);
      err_base_q <= ERR_W'(rate_target_i) - ERR_W'(gyro_rate_i);
      gyro5_q    <= GYRO5_W'(gyro_rate_i) * GYRO5_W'(GYRO_GAIN);
      axis_q     <= axis_index_i;
      armed_q    <= armed_i;
      mode_q     <= mode_switch_i;
      ridx_q     <= read_index_i;
    end
  end

  assign status_o.in_is_init = (cmd_i == CMD_INIT);

  // lfsr walk over one period
  assign lfsr_d     = (lfsr_q >> 1) ^ (lfsr_q[0] ? taps_q : '0);
  assign period_inc = period_q + LW'(1);
  assign status_o.init_last = (lfsr_d == LFSR_W'(1)) || (period_inc == LW'(MAX_SAMPLES));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init_start) begin
      lfsr_q   <= LFSR_W'(1);
      period_q <= '0;
      taps_q   <= taps_for(order_q);
    end else if (ctrl_i.init_step) begin
      lfsr_q   <= lfsr_d;
      period_q <= period_inc;
    end
  end

  // ideal capture word for the current stimulus bit
  assign lvl2      = DATA_W'(level_q) << 1;
  assign init_word = lfsr_q[0] ? (lvl2 | DATA_W'(1)) : (DATA_W'(0) - lvl2);

  // stimulus index in presamples and samples phases
  assign pre_valid     = timer_q < TIMER_W'(seq_len_q);
  assign pre_addr_full = seq_len_q - timer_q[LW-1:0] - LW'(1);
  assign samp_valid    = sidx_q < SIDX_W'(seq_len_q);
  assign stim_raddr    = (phase_q == PH_PRE) ? pre_addr_full[AW-1:0] : sidx_q[AW-1:0];
  assign stim_re       = ctrl_i.accept;
  assign cap_re        = ctrl_i.accept;

  // stores
  psis_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SAMPLES)
  ) u_stim_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.init_step),
    .waddr_i (period_q[AW-1:0]),
    .wdata_i (lfsr_q[0]),
    .re_i    (stim_re),
    .raddr_i (stim_raddr),
    .rdata_o (stim_rd)
  );

  psis_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_waddr),
    .wdata_i (cap_wdata),
    .re_i    (cap_re),
    .raddr_i (read_index_i[AW-1:0]),
    .rdata_o (cap_rd)
  );

  // phase machine for one tick on the selected axis
  assign hit    = ident_en_q && (axis_q == sel_axis_q) && (cmd_q == CMD_TICK);
  assign dc_inc = dc_q + DECIM_W'(1);
  assign acc_sum = acc_q + DATA_W'(gyro5_q);

  always_comb begin
    phase_d     = phase_q;
    timer_mid   = timer_q;
    sidx_d      = sidx_q;
    acc_d       = acc_q;
    inj_en      = 1'b0;
    bit_ok      = 1'b0;
    cap_we_tick = 1'b0;
    unique case (phase_q)
      PH_RESET: begin
        if (armed_q) begin
          if (timer_q == '0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          timer_mid = ARM_HOLDOFF;
        end
      end
      PH_IDLE: begin
        if (mode_q) begin
          phase_d   = PH_WAIT;
          timer_mid = TIMER_W'(delay_q);
        end
      end
      PH_WAIT: begin
        if (!mode_q) begin
          phase_d   = PH_IDLE;
          timer_mid = TIMER_W'(1);
        end else if (timer_q == '0) begin
          phase_d   = PH_PRE;
          timer_mid = TIMER_W'(PRESAMPLE_COUNT);
        end
      end
      PH_PRE: begin
        inj_en = 1'b1;
        bit_ok = pre_valid;
        if (timer_q == '0) begin
          phase_d   = PH_SAMPLES;
          timer_mid = TIMER_W'(seq_len_q);
          sidx_d    = '0;
        end
      end
      PH_SAMPLES: begin
        inj_en = 1'b1;
        bit_ok = samp_valid;
        acc_d  = acc_sum;
        if (dc_q == '0) begin
          cap_we_tick = samp_valid;
          if (sidx_q != SIDX_MAX) begin
            sidx_d = sidx_q + SIDX_W'(1);
          end
        end
        if (!mode_q) begin
          phase_d   = PH_IDLE;
          timer_mid = TIMER_W'(1);
        end else if (timer_q == '0) begin
          phase_d   = PH_FINISHED;
          timer_mid = TIMER_W'(1);
        end
      end
      PH_FINISHED: begin
        if (!mode_q) begin
          phase_d   = PH_IDLE;
          timer_mid = TIMER_W'(1);
        end
      end
      default: ;
    endcase

    // decimation group end steps the timer and clears the sum
    timer_d = timer_mid;
    dc_d    = dc_inc;
    if (dc_inc == decim_q) begin
      dc_d  = '0;
      acc_d = '0;
      if (timer_mid != '0) begin
        timer_d = timer_mid - TIMER_W'(1);
      end
    end
  end

  // stimulus injection and saturation
  assign bit_used = bit_ok && stim_rd;
  assign inj      = bit_used ? $signed({1'b0, level_q}) : -$signed({1'b0, level_q});
  assign err_sum  = (ERR_W+1)'(err_base_q) + (inj_en ? (ERR_W+1)'(inj) : (ERR_W+1)'(0));

  always_comb begin
    if (err_sum > ERR_SUM_MAX) begin
      err_sat = ERR_SAT_HI;
    end else if (err_sum < ERR_SUM_MIN) begin
      err_sat = ERR_SAT_LO;
    end else begin
      err_sat = err_sum[ERR_W-1:0];
    end
  end

  // capture word from the running sum and the stimulus bit
  assign tick_word = {acc_sum[DATA_W-2:0], stim_rd};
  assign read_word = (ridx_q < RIDX_W'(seq_len_q)) ? cap_rd : '0;

  // capture store write: init walk or sample capture
  assign cap_we    = ctrl_i.init_step || (ctrl_i.commit && hit && cap_we_tick);
  assign cap_waddr = ctrl_i.init_step ? period_q[AW-1:0] : sidx_q[AW-1:0];
  assign cap_wdata = ctrl_i.init_step ? init_word : tick_word;

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RESET;
      timer_q   <= '0;
      dc_q      <= '0;
      sidx_q    <= '0;
      acc_q     <= '0;
      seq_len_q <= '0;
    end else begin
      if (ctrl_i.init_step && status_o.init_last) begin
        seq_len_q <= period_inc;
      end
      if (ctrl_i.commit) begin
        if (cmd_q == CMD_INIT) begin
          phase_q <= PH_RESET;
          timer_q <= '0;
        end else if (hit) begin
          phase_q <= phase_d;
          timer_q <= timer_d;
          dc_q    <= dc_d;
          sidx_q  <= sidx_d;
          acc_q   <= acc_d;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      case (cmd_q)
        CMD_TICK: begin
          err_out_q  <= hit ? err_sat : err_base_q;
          data_out_q <= '0;
        end
        CMD_READ: begin
          err_out_q  <= '0;
          data_out_q <= read_word;
        end
        default: begin
          err_out_q  <= '0;
          data_out_q <= '0;
        end
      endcase
      if (cmd_q == CMD_INIT) begin
        phase_out_q  <= PH_RESET;
        active_out_q <= 1'b0;
      end else if (hit) begin
        phase_out_q  <= phase_d;
        active_out_q <= (phase_d == PH_SAMPLES);
      end else begin
        phase_out_q  <= phase_q;
        active_out_q <= (phase_q == PH_SAMPLES);
      end
    end
  end

  assign error_rate_o     = err_out_q;
  assign capture_data_o   = data_out_q;
  assign capture_active_o = active_out_q;
  assign phase_o          = phase_out_q;

endmodule

@@ sv/prbs_system_ident_sequencer.sv @@
// ----------------------------------------------------------------------------
// prbs_system_ident_sequencer
// PRBS stimulus injection and response capture for one flight-control axis.
// ----------------------------------------------------------------------------
// Each input beat gives one result beat. A control tick or a capture read
// is accepted, the stimulus or capture store is read through its registered
// port, and the result is registered once the output register is free. An
// init beat first walks the LFSR over one period, the length of the LFSR
// sequence (at most MAX_SAMPLES): the LFSR walk writes one stimulus bit and
// one ideal capture word per cycle. One beat is in work at a time; the next
// one is taken while the previous result still waits in the output
// register. Configuration writes are taken in any cycle.
module prbs_system_ident_sequencer
  import psis_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES     = 511,
  parameter int unsigned PRESAMPLE_COUNT = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [RATE_W-1:0] rate_target_i,
  input  logic signed [RATE_W-1:0] gyro_rate_i,
  input  logic [AXIS_W-1:0]        axis_index_i,
  input  logic                     armed_i,
  input  logic                     mode_switch_i,
  input  logic [RIDX_W-1:0]        read_index_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ERR_W-1:0]  error_rate_o,
  output logic signed [DATA_W-1:0] capture_data_o,
  output logic                     capture_active_o,
  output logic [PHASE_W-1:0]       phase_o
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // controller
  psis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // datapath
  psis_datapath #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .PRESAMPLE_COUNT (PRESAMPLE_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .rate_target_i    (rate_target_i),
    .gyro_rate_i      (gyro_rate_i),
    .axis_index_i     (axis_index_i),
    .armed_i          (armed_i),
    .mode_switch_i    (mode_switch_i),
    .read_index_i     (read_index_i),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .error_rate_o     (error_rate_o),
    .capture_data_o   (capture_data_o),
    .capture_active_o (capture_active_o),
    .phase_o          (phase_o)
  );

endmodule

@@ sv/psis_checker.sv @@
// ----------------------------------------------------------------------------
// psis_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module psis_checker
  import psis_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               capture_active_o,
  input logic [PHASE_W-1:0] phase_o
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // an accepted beat keeps the input stalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before previous beat finished");

  // a new result only appears after a beat was in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without work in progress");

  // sampling indication matches the reported phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (capture_active_o == (phase_o == PH_SAMPLES)))
    else $error("capture_active disagrees with phase");

  // only defined phase codes are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o <= PHASE_W'(PH_FINISHED)))
    else $error("undefined phase code reported");

endmodule

bind prbs_system_ident_sequencer psis_checker u_psis_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .capture_active_o (capture_active_o),
  .phase_o          (phase_o)
);
